@@ hdl/pbpa_pkg.sv @@
package pbpa_pkg;

  // pool depth and derived widths
  localparam int POOL_MAX = 16;
  localparam int ID_W     = $clog2(POOL_MAX);
  localparam int CNT_W    = $clog2(POOL_MAX + 1);
  localparam int CFG_W    = 5;

  // one list slot: buffer id and its lock bit travel together
  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            lock;
  } pbpa_entry_t;

  // command broadcast to every cell of the list
  typedef struct packed {
    logic             rebuild;
    logic             give;
    logic             recycle;
    logic [ID_W-1:0]  rec_id;
    logic [ID_W-1:0]  last;
    logic [CNT_W-1:0] size;
  } pbpa_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_COUNT
  } pbpa_state_t;

endpackage

@@ hdl/pbpa_if.sv @@
// request channel
interface pbpa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [pbpa_pkg::ID_W-1:0] buffer_id;

  modport source (output valid, mode, buffer_id, input ready);
  modport sink   (input valid, mode, buffer_id, output ready);
endinterface

// result channel
interface pbpa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [pbpa_pkg::ID_W-1:0]  given_id;
  logic [pbpa_pkg::CNT_W-1:0] available_count;

  modport source (output valid, ok, given_id, available_count, input ready);
  modport sink   (input valid, ok, given_id, available_count, output ready);
endinterface

// pool size write channel
interface pbpa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pbpa_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ hdl/pbpa_cell.sv @@
// One slot of the ordered buffer list. Shifts toward the front on a give,
// toward the back on a recycle, driven by its neighbors and a search flag.
module pbpa_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pbpa_pkg::pbpa_ctl_t           ctl_i,
  input  logic [pbpa_pkg::ID_W-1:0]     idx_i,
  input  pbpa_pkg::pbpa_entry_t         left_i,
  input  pbpa_pkg::pbpa_entry_t         right_i,
  input  pbpa_pkg::pbpa_entry_t         front_i,
  input  logic                          seen_i,
  input  logic                          run_i,
  output pbpa_pkg::pbpa_entry_t         ent_o,
  output logic                          seen_o,
  output logic                          run_o
);

  pbpa_pkg::pbpa_entry_t ent_r;
  pbpa_pkg::pbpa_entry_t ent_nxt;
  logic                  in_range;

  assign in_range = {1'b0, idx_i} < ctl_i.size;

  // search flag: recycled id found at or ahead of this slot
  assign seen_o = seen_i | (ent_r.id == ctl_i.rec_id);
  // run of unlocked slots from the front
  assign run_o  = run_i & in_range & ~ent_r.lock;
  assign ent_o  = ent_r;

  // next slot content
  always_comb begin
    ent_nxt = ent_r;
    if (ctl_i.rebuild) begin
      ent_nxt.id   = idx_i;
      ent_nxt.lock = 1'b0;
    end else if (ctl_i.give) begin
      if (idx_i == ctl_i.last) begin
        ent_nxt.id   = front_i.id;
        ent_nxt.lock = 1'b1;
      end else if (in_range) begin
        ent_nxt = right_i;
      end
    end else if (ctl_i.recycle) begin
      if (idx_i == '0) begin
        ent_nxt.id   = ctl_i.rec_id;
        ent_nxt.lock = 1'b0;
      end else if (!seen_i) begin
        ent_nxt = left_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.id   <= idx_i;
      ent_r.lock <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

@@ hdl/packet_buffer_pool_allocator_core.sv @@
// Channel   Dir  Fields                               Transfer when
// in_req    in   mode, buffer_id                      valid & ready
// out_rsp   out  ok, given_id, available_count        valid & ready
// cfg_wr    in   data (pool size, saturates at 16)    valid & ready (ready held high)
//
// Per request, the list cells update on the accepting edge, then the count state
// counts the leading unlocked slots and loads the result register. New requests
// are taken only in idle. A waiting result does not block the next request; a
// request finishing while the result register is still full waits in the count state.
// Reset (synchronous, rst_n low) restores a full pool in ascending order.
module packet_buffer_pool_allocator_core (
  input  logic               clk,
  input  logic               rst_n,
  pbpa_req_if.sink           in_req,
  pbpa_rsp_if.source         out_rsp,
  pbpa_cfg_if.sink           cfg_wr
);

  pbpa_pkg::pbpa_state_t                 state_r;
  pbpa_pkg::pbpa_state_t                 state_nxt;
  logic [pbpa_pkg::CNT_W-1:0]            size_r;
  logic [pbpa_pkg::CNT_W-1:0]            size_nxt;
  logic                                  ok_r;
  logic [pbpa_pkg::ID_W-1:0]             given_r;
  logic                                  out_valid_r;
  logic                                  out_valid_nxt;
  logic                                  out_ok_r;
  logic [pbpa_pkg::ID_W-1:0]             out_given_r;
  logic [pbpa_pkg::CNT_W-1:0]            out_cnt_r;
  logic                                  load;
  logic                                  accept;
  logic                                  cfg_wr_en;
  logic                                  give_ok;
  logic                                  rec_ok;
  logic [pbpa_pkg::CNT_W-1:0]            avail;
  pbpa_pkg::pbpa_ctl_t                   ctl;
  pbpa_pkg::pbpa_entry_t                 ent [pbpa_pkg::POOL_MAX];
  logic [pbpa_pkg::POOL_MAX:0]           seen;
  logic [pbpa_pkg::POOL_MAX:0]           run;

  assign in_req.ready = (state_r == pbpa_pkg::ST_IDLE);
  assign cfg_wr.ready = 1'b1;
  assign accept       = in_req.valid & in_req.ready;
  assign cfg_wr_en    = cfg_wr.valid & cfg_wr.ready;

  // request qualification
  assign give_ok = (size_r != '0) & ~ent[0].lock;
  assign rec_ok  = {1'b0, in_req.buffer_id} < size_r;

  // command to the cells
  always_comb begin
    ctl.rebuild = cfg_wr_en;
    ctl.give    = accept & ~in_req.mode & give_ok;
    ctl.recycle = accept & in_req.mode & rec_ok;
    ctl.rec_id  = in_req.buffer_id;
    ctl.last    = pbpa_pkg::ID_W'(size_r - pbpa_pkg::CNT_W'(1));
    ctl.size    = size_r;
  end

  // list of cells
  assign seen[0] = 1'b0;
  assign run[0]  = 1'b1;
  for (genvar g = 0; g < pbpa_pkg::POOL_MAX; g++) begin : g_cell
    pbpa_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl),
      .idx_i   (pbpa_pkg::ID_W'(g)),
      .left_i  (ent[(g == 0) ? 0 : g - 1]),
      .right_i (ent[(g == pbpa_pkg::POOL_MAX - 1) ? g : g + 1]),
      .front_i (ent[0]),
      .seen_i  (seen[g]),
      .run_i   (run[g]),
      .ent_o   (ent[g]),
      .seen_o  (seen[g+1]),
      .run_o   (run[g+1])
    );
  end

  // leading unlocked slots
  always_comb begin
    avail = '0;
    for (int i = 1; i <= pbpa_pkg::POOL_MAX; i++) begin
      avail = avail + pbpa_pkg::CNT_W'(run[i]);
    end
  end

  // pool size register
  always_comb begin
    size_nxt = size_r;
    if (cfg_wr_en) begin
      if (int'(cfg_wr.data) > pbpa_pkg::POOL_MAX) begin
        size_nxt = pbpa_pkg::CNT_W'(pbpa_pkg::POOL_MAX);
      end else begin
        size_nxt = pbpa_pkg::CNT_W'(cfg_wr.data);
      end
    end
  end

  // sequencer and output register control
  always_comb begin
    state_nxt     = state_r;
    load          = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      pbpa_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = pbpa_pkg::ST_COUNT;
        end
      end
      pbpa_pkg::ST_COUNT: begin
        if (!out_valid_r || out_rsp.ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pbpa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pbpa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbpa_pkg::ST_IDLE;
      size_r      <= pbpa_pkg::CNT_W'(pbpa_pkg::POOL_MAX);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r    <= in_req.mode ? rec_ok : give_ok;
      given_r <= (!in_req.mode && give_ok) ? ent[0].id : '0;
    end
    if (load) begin
      out_ok_r    <= ok_r;
      out_given_r <= given_r;
      out_cnt_r   <= avail;
    end
  end

  assign out_rsp.valid           = out_valid_r;
  assign out_rsp.ok              = out_ok_r;
  assign out_rsp.given_id        = out_given_r;
  assign out_rsp.available_count = out_cnt_r;

`ifndef SYNTHESIS
  a_accept_to_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == pbpa_pkg::ST_COUNT)
    else $error("request did not move to count state");

  a_count_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> avail <= size_r)
    else $error("available count exceeds pool size");

  a_failed_give_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !in_req.mode && !give_ok && !cfg_wr_en |=> $stable(ent[0]))
    else $error("failed give changed the list front");

  a_given_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_given_r != '0) |-> out_ok_r)
    else $error("buffer id handed out on a failed request");
`endif

endmodule

@@ verif/packet_buffer_pool_allocator_core_tb.sv @@
module packet_buffer_pool_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 6;

  typedef enum logic {
    MODE_GIVE    = 1'b0,
    MODE_RECYCLE = 1'b1
  } pool_op_t;

  typedef struct packed {
    pool_op_t                  mode;
    logic [pbpa_pkg::ID_W-1:0] buffer_id;
  } pool_req_t;

  typedef struct packed {
    logic                       ok;
    logic [pbpa_pkg::ID_W-1:0]  given_id;
    logic [pbpa_pkg::CNT_W-1:0] avail;
  } pool_grant_t;

  logic clk;
  logic rst_n;

  pbpa_req_if req_ch ();
  pbpa_rsp_if rsp_ch ();
  pbpa_cfg_if cfg_ch ();

  packet_buffer_pool_allocator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  // shadow copy of the buffer list
  logic [pbpa_pkg::ID_W-1:0] pool_order  [pbpa_pkg::POOL_MAX];
  logic                      pool_locked [pbpa_pkg::POOL_MAX];
  int                        pool_len;

  pool_req_t   pending_reqs [$];
  pool_grant_t awaited_grants [$];

  logic req_taken;
  logic rx_hold;
  bit   hold_go;
  int   tx_idle_pct;
  int   rx_idle_pct;
  int   cycles;
  int   errors;
  int   cfg_writes;
  int   n_granted, n_refused, n_recycled, n_rejected;

  // rebuild the list ascending, all unlocked
  function automatic void pool_rebuild(int sz);
    pool_len = (sz > pbpa_pkg::POOL_MAX) ? pbpa_pkg::POOL_MAX : sz;
    for (int i = 0; i < pbpa_pkg::POOL_MAX; i++) begin
      pool_order[i]  = pbpa_pkg::ID_W'(i);
      pool_locked[i] = 1'b0;
    end
  endfunction

  // apply one request to the shadow list and return the grant it yields
  function automatic pool_grant_t apply_request(pool_req_t r);
    pool_grant_t               g;
    logic [pbpa_pkg::ID_W-1:0] head;
    int                        pos;
    int                        n;
    g = '0;
    if (r.mode == MODE_GIVE) begin
      if (pool_len > 0) begin
        head = pool_order[0];
        if (!pool_locked[head]) begin
          pool_locked[head] = 1'b1;
          for (int i = 0; i + 1 < pool_len; i++) pool_order[i] = pool_order[i+1];
          pool_order[pool_len-1] = head;
          g.ok       = 1'b1;
          g.given_id = head;
        end
      end
    end else if (int'(r.buffer_id) < pool_len) begin
      pos = 0;
      while (pos < pool_len && pool_order[pos] != r.buffer_id) pos++;
      if (pos < pool_len) begin
        pool_locked[r.buffer_id] = 1'b0;
        for (int i = pos; i > 0; i--) pool_order[i] = pool_order[i-1];
        pool_order[0] = r.buffer_id;
        g.ok = 1'b1;
      end
    end
    // leading run of unlocked ids
    n = 0;
    while (n < pool_len && !pool_locked[pool_order[n]]) n++;
    g.avail = pbpa_pkg::CNT_W'(n);
    return g;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // known values on every input from time zero
  initial begin
    rst_n            = 1'b0;
    req_ch.valid     = 1'b0;
    req_ch.mode      = 1'b0;
    req_ch.buffer_id = '0;
    rsp_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.data      = '0;
  end

  // cycle limit
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("packet_buffer_pool_allocator_core verification failed");
      $finish;
    end
  end

  // request driver: next item goes out once the current one transferred
  always @(negedge clk) begin
    pool_req_t nxt;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = pending_reqs[0];
        pending_reqs.delete(0);
        req_ch.valid     <= 1'b1;
        req_ch.mode      <= nxt.mode;
        req_ch.buffer_id <= nxt.buffer_id;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  always @(negedge clk) begin
    if (!rst_n) rsp_ch.ready <= 1'b0;
    else rsp_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // long receiver hold-off, counted here
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(negedge clk) rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold <= 1'b0;
  end

  // monitor: check results, predict on accepted requests and writes
  always @(posedge clk) begin
    pool_grant_t exp_g;
    pool_grant_t got;
    pool_req_t   r;
    if (!rst_n) begin
      pool_rebuild(pbpa_pkg::POOL_MAX);
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_grants.size() == 0) begin
          $error("unexpected result transfer: ok=%0d given_id=%0d available_count=%0d",
                 rsp_ch.ok, rsp_ch.given_id, rsp_ch.available_count);
          errors++;
        end else begin
          exp_g = awaited_grants[0];
          awaited_grants.delete(0);
          if (rsp_ch.ok !== exp_g.ok) begin
            $error("ok mismatch: expected %0d, actual %0d", exp_g.ok, rsp_ch.ok);
            errors++;
          end
          if (rsp_ch.given_id !== exp_g.given_id) begin
            $error("given_id mismatch: expected %0d, actual %0d",
                   exp_g.given_id, rsp_ch.given_id);
            errors++;
          end
          if (rsp_ch.available_count !== exp_g.avail) begin
            $error("available_count mismatch: expected %0d, actual %0d",
                   exp_g.avail, rsp_ch.available_count);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        r.mode      = pool_op_t'(req_ch.mode);
        r.buffer_id = req_ch.buffer_id;
        got = apply_request(r);
        awaited_grants.insert(awaited_grants.size(), got);
        if (r.mode == MODE_GIVE) begin
          if (got.ok) n_granted++;
          else n_refused++;
        end else begin
          if (got.ok) n_recycled++;
          else n_rejected++;
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        pool_rebuild(int'(cfg_ch.data));
        cfg_writes++;
      end
    end
  end

  task automatic add_req(pool_op_t m, int id);
    pool_req_t r;
    r.mode      = m;
    r.buffer_id = pbpa_pkg::ID_W'(id);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // wait until the block has nothing in flight
  task automatic drain();
    while (pending_reqs.size() != 0 || req_ch.valid || awaited_grants.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // pool size write, only issued while idle
  task automatic set_pool(int v);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= pbpa_pkg::CFG_W'(v);
    wait (cfg_writes != seen);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  initial begin
    int pool_plan [$];
    int eff;
    int budget;
    int give_pct;
    int added;
    int burst;
    errors      = 0;
    cfg_writes  = 0;
    n_granted   = 0;
    n_refused   = 0;
    n_recycled  = 0;
    n_rejected  = 0;
    hold_go     = 1'b0;
    tx_idle_pct = 29;
    rx_idle_pct = 52;
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // full pool after reset: hand out all, then one more against a locked front
    repeat (pbpa_pkg::POOL_MAX + 1) add_req(MODE_GIVE, 0);
    add_req(MODE_RECYCLE, 5);   // locked id back to the front
    add_req(MODE_RECYCLE, 5);   // already unlocked, still moves to front
    add_req(MODE_GIVE, 9);
    drain();

    // empty pool
    set_pool(0);
    add_req(MODE_GIVE, 0);
    add_req(MODE_RECYCLE, 0);
    drain();

    // single buffer, out-of-range recycle
    set_pool(1);
    add_req(MODE_GIVE, 15);
    add_req(MODE_GIVE, 0);
    add_req(MODE_RECYCLE, 3);
    add_req(MODE_RECYCLE, 0);
    drain();

    // random phases over a spread of pool sizes, oversized ones saturate
    pool_plan = '{31, 2, 16, 1, 16, 17, 0, 5, 16, 16};
    pool_plan.insert(pool_plan.size(), $urandom_range(1, 30));
    pool_plan.insert(pool_plan.size(), $urandom_range(1, 31));
    foreach (pool_plan[k]) begin
      if (k < 4) begin
        tx_idle_pct = 29;
        rx_idle_pct = 52;
      end else if (k < 8) begin
        tx_idle_pct = 52;
        rx_idle_pct = 29;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_pool(pool_plan[k]);
      eff      = (pool_plan[k] > pbpa_pkg::POOL_MAX) ? pbpa_pkg::POOL_MAX : pool_plan[k];
      budget   = (eff == 0) ? 20 : 110;
      give_pct = $urandom_range(35, 70);
      added    = 0;
      while (added < budget) begin
        if ($urandom_range(0, 9) == 0) begin
          // run the pool dry and past it
          burst = eff + 1;
          repeat (burst) add_req(MODE_GIVE, $urandom_range(0, 15));
          added += burst;
        end else begin
          if ($urandom_range(0, 99) < give_pct)
            add_req(MODE_GIVE, $urandom_range(0, 15));
          else if (eff > 0 && $urandom_range(0, 99) < 80)
            add_req(MODE_RECYCLE, $urandom_range(0, eff - 1));
          else
            add_req(MODE_RECYCLE, $urandom_range(0, 15));
          added++;
        end
      end
      // results stall for a long stretch while requests keep coming
      if (k == 9) hold_go = 1'b1;
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Run covered %0d requests across %0d pool size writes (sizes 0 to 31).",
             n_granted + n_refused + n_recycled + n_rejected, cfg_writes);
    $display("Grants %0d, refused gives %0d, recycles taken %0d, recycles rejected %0d.",
             n_granted, n_refused, n_recycled, n_rejected);
    if (errors == 0 && awaited_grants.size() == 0) begin
      $display("packet_buffer_pool_allocator_core verification clean");
    end else begin
      $display("packet_buffer_pool_allocator_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/pbpa_pkg.sv
hdl/pbpa_if.sv
hdl/pbpa_cell.sv
hdl/packet_buffer_pool_allocator_core.sv
verif/packet_buffer_pool_allocator_core_tb.sv
